// ===== sv/fpalu_pkg.sv =====
package fpalu_pkg;

    // Operation codes carried in req_type.
    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_GT       = 4'd4;
    localparam logic [3:0] OP_LT       = 4'd5;
    localparam logic [3:0] OP_GE       = 4'd6;
    localparam logic [3:0] OP_LE       = 4'd7;
    localparam logic [3:0] OP_EQ       = 4'd8;
    localparam logic [3:0] OP_NE       = 4'd9;
    localparam logic [3:0] OP_MIN      = 4'd10;
    localparam logic [3:0] OP_MAX      = 4'd11;
    localparam logic [3:0] OP_INC      = 4'd12;
    localparam logic [3:0] OP_DEC      = 4'd13;
    localparam logic [3:0] OP_FROM_INT = 4'd14;
    localparam logic [3:0] OP_TO_INT   = 4'd15;

    // Status codes.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_DIV0 = 1'b1;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               status;
    } t_rsp;

    // What the divider pipeline hands back: the low quotient bits as a
    // magnitude, the sign to apply, and the divide-by-zero flag.
    typedef struct packed {
        logic [31:0] quot;
        logic        neg;
        logic        div0;
    } t_div_res;

    // Non-divide result that rides alongside the divider.
    typedef struct packed {
        logic        is_div;
        logic [31:0] value;
        logic        cmp;
    } t_side;

endpackage

// ===== sv/fpalu_div_pipe.sv =====
module fpalu_div_pipe #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic signed [31:0]    i_dividend,
    input  logic signed [31:0]    i_divisor,
    output fpalu_pkg::t_div_res   o_res
);
    import fpalu_pkg::*;

    // The dividend magnitude is shifted left by the fraction bits, so the
    // quotient has this many bits and the pipeline has this many steps.
    localparam int NW = 32 + FRAC_BITS;

    logic [31:0]   r_rem [0:NW];
    logic [NW-1:0] r_nq  [0:NW];
    logic [31:0]   r_dv  [0:NW];
    logic          r_neg [0:NW];
    logic          r_dz  [0:NW];

    logic [31:0] mag_a;
    logic [31:0] mag_b;

    assign mag_a = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
    assign mag_b = i_divisor[31]  ? (32'd0 - i_divisor)  : i_divisor;

    // Setup stage: take magnitudes and note the quotient sign.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_nq[0]  <= NW'(mag_a) << FRAC_BITS;
        r_dv[0]  <= mag_b;
        r_neg[0] <= i_dividend[31] ^ i_divisor[31];
        r_dz[0]  <= (i_divisor == 32'sd0);
    end

    // One restoring step per stage. The dividend bits shift out of the top
    // of r_nq while quotient bits shift in at the bottom.
    for (genvar k = 1; k <= NW; k++) begin : g_step
        logic [32:0] trial;
        logic [33:0] diff;

        assign trial = {r_rem[k-1], r_nq[k-1][NW-1]};
        assign diff  = {1'b0, trial} - {2'b00, r_dv[k-1]};

        always_ff @(posedge i_clk) begin
            if (diff[33]) begin
                r_rem[k] <= trial[31:0];
                r_nq[k]  <= {r_nq[k-1][NW-2:0], 1'b0};
            end else begin
                r_rem[k] <= diff[31:0];
                r_nq[k]  <= {r_nq[k-1][NW-2:0], 1'b1};
            end
            r_dv[k]  <= r_dv[k-1];
            r_neg[k] <= r_neg[k-1];
            r_dz[k]  <= r_dz[k-1];
        end
    end

    assign o_res.quot = r_nq[NW][31:0];
    assign o_res.neg  = r_neg[NW];
    assign o_res.div0 = r_dz[NW];

endmodule

// ===== sv/fixed_point_alu_unit.sv =====
// Signed fixed-point ALU with FRAC_BITS fraction bits, results wrapped to
// DATA_WIDTH bits and presented in 32-bit fields.
//
// Request channel: a word on i_req is taken at each rising edge where start
// is high and busy is low. Result channel: o_rsp carries one word for exactly
// one cycle while o_strobe is high; the receiver cannot hold it off.
//
// The block is a fixed-latency pipeline. Once busy has dropped after reset, a
// request word may be issued every cycle, so throughput is one word per clock.
// The pipeline depth is set by the divider, which resolves one quotient bit
// per stage over 32 + FRAC_BITS stages; all other operations are computed
// early and travel down a matching delay line so results leave in order.
//
// Synchronous active-low reset clears every valid bit, so no stale result is
// strobed afterwards, and holds busy high for the reset cycle; busy drops on
// the first clock after reset is released and stays low from then on.
// Divide by zero returns zero with status set.
module fixed_point_alu_unit #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  fpalu_pkg::t_req  i_req,
    output logic             busy,
    output logic             o_strobe,
    output fpalu_pkg::t_rsp  o_rsp
);
    import fpalu_pkg::*;

    // Divider stages; the delay line for other operations matches them.
    localparam int NW = 32 + FRAC_BITS;
    // Shift that sign-extends from bit DATA_WIDTH-1 within a 32-bit field.
    localparam int WRAP_SH = (DATA_WIDTH < 32) ? 32 - DATA_WIDTH : 0;
    // Edges from the accepting edge to the edge that takes the result.
    localparam int ACC_TO_OUT = NW + 3;

    // Wrap a value to DATA_WIDTH bits and sign-extend it into the field.
    function automatic logic [31:0] wrap_dw(input logic [31:0] v);
        logic signed [31:0] t;
        t = v << WRAP_SH;
        return 32'(t >>> WRAP_SH);
    endfunction

    logic accept;

    logic               r_busy;
    logic               r_s1_vld;
    logic [3:0]         r_s1_op;
    logic signed [31:0] r_s1_a;
    logic signed [31:0] r_s1_b;

    logic               r_s2_vld;
    logic               r_s2_is_mul;
    logic               r_s2_is_div;
    logic [31:0]        r_s2_val;
    logic               r_s2_cmp;
    logic signed [63:0] r_s2_prod;

    logic [31:0]        n_s2_val;
    logic               n_s2_cmp;
    logic               lt_ab;
    logic               lt_ba;

    t_side              n_side;
    t_side              r_pipe [0:NW-1];
    logic [NW-1:0]      r_pipe_vld;

    t_div_res           div_res;
    t_rsp               n_rsp;
    t_rsp               r_rsp;
    logic               r_strobe;

    assign accept   = start && !r_busy;
    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // Busy only covers the reset cycle; the pipeline itself never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Stage 1: register the request with operands wrapped to DATA_WIDTH.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op <= i_req.req_type;
        r_s1_a  <= wrap_dw(i_req.operand_a);
        r_s1_b  <= wrap_dw(i_req.operand_b);
    end

    // Stage 2: the cheap operations, plus the full signed product.
    always_comb begin
        n_s2_val = '0;
        n_s2_cmp = 1'b0;
        lt_ab    = r_s1_a < r_s1_b;
        lt_ba    = r_s1_b < r_s1_a;
        case (r_s1_op)
            OP_ADD:      n_s2_val = 32'(r_s1_a + r_s1_b);
            OP_SUB:      n_s2_val = 32'(r_s1_a - r_s1_b);
            OP_GT:       n_s2_cmp = lt_ba;
            OP_LT:       n_s2_cmp = lt_ab;
            OP_GE:       n_s2_cmp = !lt_ab;
            OP_LE:       n_s2_cmp = !lt_ba;
            OP_EQ:       n_s2_cmp = (r_s1_a == r_s1_b);
            OP_NE:       n_s2_cmp = (r_s1_a != r_s1_b);
            // On a tie both min and max return operand b.
            OP_MIN:      n_s2_val = lt_ab ? r_s1_a : r_s1_b;
            OP_MAX:      n_s2_val = lt_ba ? r_s1_a : r_s1_b;
            OP_INC:      n_s2_val = 32'(r_s1_a + 32'sd1);
            OP_DEC:      n_s2_val = 32'(r_s1_a - 32'sd1);
            OP_FROM_INT: n_s2_val = 32'(r_s1_a <<< FRAC_BITS);
            OP_TO_INT:   n_s2_val = 32'(r_s1_a >>> FRAC_BITS);
            default:     n_s2_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_is_mul <= (r_s1_op == OP_MUL);
        r_s2_is_div <= (r_s1_op == OP_DIV);
        r_s2_val    <= wrap_dw(n_s2_val);
        r_s2_cmp    <= n_s2_cmp;
        r_s2_prod   <= r_s1_a * r_s1_b;
    end

    // Stage 3: fold the scaled product in, then delay to match the divider.
    always_comb begin
        n_side.is_div = r_s2_is_div;
        n_side.cmp    = r_s2_cmp;
        n_side.value  = r_s2_is_mul ? wrap_dw(r_s2_prod[FRAC_BITS +: 32]) : r_s2_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe_vld <= '0;
        end else begin
            r_pipe_vld <= {r_pipe_vld[NW-2:0], r_s2_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= n_side;
    end

    for (genvar k = 1; k < NW; k++) begin : g_delay
        always_ff @(posedge i_clk) begin
            r_pipe[k] <= r_pipe[k-1];
        end
    end

    // The divider runs on every stage-1 word; its answer is only used for
    // divide requests and lines up with the last delay stage.
    fpalu_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_dividend (r_s1_a),
        .i_divisor  (r_s1_b),
        .o_res      (div_res)
    );

    // Output stage: apply the quotient sign and pick the result.
    always_comb begin
        n_rsp.result_value = '0;
        n_rsp.compare_true = 1'b0;
        n_rsp.status       = ST_OK;
        if (r_pipe[NW-1].is_div) begin
            if (div_res.div0) begin
                n_rsp.status = ST_DIV0;
            end else begin
                n_rsp.result_value = wrap_dw(div_res.neg ? (32'd0 - div_res.quot)
                                                         : div_res.quot);
            end
        end else begin
            n_rsp.result_value = r_pipe[NW-1].value;
            n_rsp.compare_true = r_pipe[NW-1].cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_pipe_vld[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    // Every accepted word comes out exactly once, at a fixed distance.
    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##ACC_TO_OUT o_strobe)
        else $error("accepted word did not produce a result on time");

    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, ACC_TO_OUT))
        else $error("result strobed without a matching request");

    a_div0_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status) |->
            ($past(i_req.req_type == OP_DIV, ACC_TO_OUT) && o_rsp.result_value == 32'sd0)
        ) else $error("divide-by-zero status on a non-divide or nonzero result");

    a_cmp_from_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.compare_true) |->
            $past((i_req.req_type >= OP_GT) && (i_req.req_type <= OP_NE), ACC_TO_OUT))
        else $error("compare flag set for a non-compare operation");

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpalu_pkg::*;

    // The block is built with its default format, Q24.8 in 32-bit words.
    localparam int FRAC_BITS  = 8;
    localparam int DATA_WIDTH = 32;

    // The drain at the end waits well past the pipeline depth. The watchdog
    // trips when neither side has moved a word for far longer than the
    // pipeline depth plus the longest sender gap.
    localparam int PIPE_LATENCY = 34 + FRAC_BITS;
    localparam int DRAIN_CYCLES = 3 * PIPE_LATENCY;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1950;

    localparam logic signed [31:0] RAW_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RAW_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] RAW_ONE = 32'sd1 <<< FRAC_BITS;

    // One row of the directed table. When has_typed is set, the expected
    // word is the one typed into the row. Otherwise the ALU model supplies it.
    typedef struct packed {
        t_req req;
        logic has_typed;
        t_rsp rsp;
    } t_dir_row;

    localparam int DIR_ROWS = 25;

    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // Add and subtract that run off the ends of the range wrap around.
        '{'{OP_ADD, RAW_MAX, 32'sd1},       1'b1, '{RAW_MIN, 1'b0, ST_OK}},
        '{'{OP_SUB, RAW_MIN, 32'sd1},       1'b1, '{RAW_MAX, 1'b0, ST_OK}},
        '{'{OP_ADD, RAW_ONE, 32'sd512},     1'b0, '0},
        // Multiply: unity, the most negative squared, and a product that
        // rounds toward minus infinity.
        '{'{OP_MUL, RAW_ONE, RAW_ONE},      1'b0, '0},
        '{'{OP_MUL, RAW_MIN, RAW_MIN},      1'b0, '0},
        '{'{OP_MUL, -32'sd1, 32'sd1},       1'b0, '0},
        // Divide by zero returns zero with the error status.
        '{'{OP_DIV, 32'sd512, 32'sd0},      1'b1, '{32'sd0, 1'b0, ST_DIV0}},
        '{'{OP_DIV, RAW_MIN, 32'sd0},       1'b1, '{32'sd0, 1'b0, ST_DIV0}},
        '{'{OP_DIV, 32'sd768, RAW_ONE},     1'b0, '0},
        '{'{OP_DIV, RAW_MIN, -32'sd1},      1'b0, '0},
        '{'{OP_DIV, -32'sd1, 32'sd512},     1'b0, '0},
        // The six comparisons. A comparison always returns a zero value.
        '{'{OP_GT, RAW_MAX, RAW_MIN},       1'b1, '{32'sd0, 1'b1, ST_OK}},
        '{'{OP_LT, RAW_MIN, RAW_MAX},       1'b1, '{32'sd0, 1'b1, ST_OK}},
        '{'{OP_GE, 32'sd5, 32'sd5},         1'b0, '0},
        '{'{OP_LE, 32'sd5, -32'sd5},        1'b0, '0},
        '{'{OP_EQ, RAW_MIN, RAW_MIN},       1'b1, '{32'sd0, 1'b1, ST_OK}},
        '{'{OP_NE, 32'sd0, 32'sd0},         1'b0, '0},
        // Min of equal operands, and max across the full range.
        '{'{OP_MIN, 32'sd3, 32'sd3},        1'b0, '0},
        '{'{OP_MAX, RAW_MIN, RAW_MAX},      1'b1, '{RAW_MAX, 1'b0, ST_OK}},
        // Increment and decrement by one raw unit wrap at the extremes.
        '{'{OP_INC, RAW_MAX, RAW_MIN},      1'b1, '{RAW_MIN, 1'b0, ST_OK}},
        '{'{OP_DEC, RAW_MIN, RAW_MAX},      1'b1, '{RAW_MAX, 1'b0, ST_OK}},
        // Conversions: integer to fixed wraps, and fixed to integer rounds
        // toward minus infinity.
        '{'{OP_FROM_INT, RAW_MAX, 32'sd0},  1'b0, '0},
        '{'{OP_FROM_INT, -32'sd3, 32'sd9},  1'b0, '0},
        '{'{OP_TO_INT, -32'sd1, 32'sd0},    1'b1, '{-32'sd1, 1'b0, ST_OK}},
        '{'{OP_TO_INT, RAW_MIN, RAW_MAX},   1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    // Expected result words, oldest first, plus the run statistics.
    t_rsp pending_rsp [$];
    int   mismatch_count = 0;
    int   words_checked  = 0;
    int   words_sent     = 0;
    int   div0_sent      = 0;
    int   idle_cycles    = 0;

    fixed_point_alu_unit #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // Free-running 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sign-extend the low DATA_WIDTH bits of a 64-bit value.
    function automatic logic signed [63:0] wrap_width(input logic signed [63:0] v);
        return (v <<< (64 - DATA_WIDTH)) >>> (64 - DATA_WIDTH);
    endfunction

    // ALU model. Operands are widened to 64 bits, where every operation is
    // exact, and the outcome is then wrapped back to the data width.
    function automatic t_rsp alu_compute(input t_req w);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] full;
        t_rsp r;
        a = wrap_width(64'(w.operand_a));
        b = wrap_width(64'(w.operand_b));
        full = '0;
        r = '0;
        r.status = ST_OK;
        case (w.req_type)
            OP_ADD:      full = a + b;
            OP_SUB:      full = a - b;
            // A 32 by 32 product fits in 64 bits, so the shift sees the
            // whole product.
            OP_MUL:      full = (a * b) >>> FRAC_BITS;
            OP_DIV: begin
                if (b == 0) begin
                    r.status = ST_DIV0;
                end else begin
                    // Signed division truncates toward zero.
                    full = (a <<< FRAC_BITS) / b;
                end
            end
            OP_GT:       r.compare_true = (a > b);
            OP_LT:       r.compare_true = (a < b);
            OP_GE:       r.compare_true = (a >= b);
            OP_LE:       r.compare_true = (a <= b);
            OP_EQ:       r.compare_true = (a == b);
            OP_NE:       r.compare_true = (a != b);
            // On a tie, both min and max hand back operand_b.
            OP_MIN:      full = (a < b) ? a : b;
            OP_MAX:      full = (b < a) ? a : b;
            OP_INC:      full = a + 64'sd1;
            OP_DEC:      full = a - 64'sd1;
            OP_FROM_INT: full = a <<< FRAC_BITS;
            OP_TO_INT:   full = a >>> FRAC_BITS;
        endcase
        full = wrap_width(full);
        r.result_value = full[31:0];
        return r;
    endfunction

    // Operands come from a mix of sources: any bit pattern, small raw values
    // near zero, the extremes, and ordinary fixed-point numbers.
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(0, 2048)) - 32'd1024;
            1: begin
                case ($urandom_range(0, 5))
                    0: return RAW_MIN;
                    1: return RAW_MAX;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    4: return 32'sd1;
                    default: return RAW_ONE;
                endcase
            end
            2: return (32'($urandom_range(0, 65535)) - 32'd32768) << FRAC_BITS;
            default: return $urandom;
        endcase
    endfunction

    // Holds start low and puts noise on the request bus, repeating this n times. A
    // word is taken only while start is high, so the noise must be ignored.
    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= {4'($urandom), $urandom, $urandom};
        end
    endtask

    // Presents one request word from the falling edge onward and waits for
    // the rising edge that takes it. Then it queues the expected result word.
    // Start stays high on return, so back-to-back words get no gap.
    task automatic send_word(input t_req w, input logic has_typed, input t_rsp typed_rsp);
        t_rsp expected;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= w;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        expected = has_typed ? typed_rsp : alu_compute(w);
        if (expected.status == ST_DIV0) div0_sent++;
        words_sent++;
        pending_rsp.push_back(expected);
    endtask

    // Result checker. The receiver cannot hold results off, so every strobe
    // is a word that must match the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (o_strobe === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: result word strobed with none expected: value %0d cmp %0b st %0b",
                         $time, o_rsp.result_value, o_rsp.compare_true, o_rsp.status);
                mismatch_count++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                words_checked++;
                if (o_rsp.result_value !== exp_rsp.result_value) begin
                    $display("%0t: result_value mismatch: expected %0d, actual %0d",
                             $time, exp_rsp.result_value, o_rsp.result_value);
                    mismatch_count++;
                end
                if (o_rsp.compare_true !== exp_rsp.compare_true) begin
                    $display("%0t: compare_true mismatch: expected %0b, actual %0b",
                             $time, exp_rsp.compare_true, o_rsp.compare_true);
                    mismatch_count++;
                end
                if (o_rsp.status !== exp_rsp.status) begin
                    $display("%0t: status mismatch: expected %0b, actual %0b",
                             $time, exp_rsp.status, o_rsp.status);
                    mismatch_count++;
                end
            end
        end else if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            $display("%0t: strobe unknown: expected 0, actual %b", $time, o_strobe);
            mismatch_count++;
        end
    end

    // Watchdog. A cycle counts as idle when no request word is taken and no
    // result word is strobed. A long run of idle cycles means the block has
    // hung.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d words outstanding",
                     $time, idle_cycles, pending_rsp.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        t_req word;
        int   burst_left;
        int   pick;
        // Every input is known from time zero. Reset is held low from the start
        // and released on a falling edge, away from the sampling edge.
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: the extremes, every opcode, and the special cases.
        // Short random gaps between some rows put idle cycles in the pipeline.
        for (int i = 0; i < DIR_ROWS; i++) begin
            if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 4));
            send_word(DIRECTED[i].req, DIRECTED[i].has_typed, DIRECTED[i].rsp);
        end

        // Random part. The sender works in bursts of random length. Some
        // bursts follow straight on from the last, so the pipeline also sees
        // long unbroken stretches of words.
        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
                burst_left = $urandom_range(1, 48);
            end
            burst_left--;
            word.req_type  = 4'($urandom_range(0, 15));
            word.operand_a = pick_operand();
            word.operand_b = pick_operand();
            // Zero divisors and equal operands are forced often enough that
            // the divide-by-zero case and the tie cases come up again and again.
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                word.operand_b = 32'sd0;
            end else if (pick <= 2) begin
                word.operand_b = word.operand_a;
            end
            send_word(word, 1'b0, '0);
        end
        hold_off(1);

        // Wait for every outstanding result, then drain a while longer so
        // that a stray extra strobe is caught. The watchdog bounds the wait.
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d request words over all 16 opcodes, %0d of them divides by zero.",
                 words_sent, div0_sent);
        $display("Checked %0d result words, %0d mismatches.", words_checked, mismatch_count);
        if (mismatch_count == 0 && pending_rsp.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
